/* hdl/mtq_pkg.sv */
// Shared types and constants for the matrix-to-quaternion pipeline.
package mtq_pkg;

  // The largest normalized magnitude lies in [2^29, 2^30); the others are no larger.
  localparam int MAG_W  = 30;
  localparam int ROOT_W = MAG_W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int N_W    = 2 * MAG_W + 2;

  localparam logic [1:0] PIV_W = 2'd0;
  localparam logic [1:0] PIV_X = 2'd1;
  localparam logic [1:0] PIV_Y = 2'd2;
  localparam logic [1:0] PIV_Z = 2'd3;

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic [3:0] neg;
    logic [1:0] pivot;
    logic       inv;
  } side_t;

endpackage

/* hdl/mtq_front.sv */
// Front stages: pivot choice, component formation, sign split and normalizing shift.
module mtq_front #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic signed [DATA_WIDTH-1:0] m00,
  input  logic signed [DATA_WIDTH-1:0] m01,
  input  logic signed [DATA_WIDTH-1:0] m02,
  input  logic signed [DATA_WIDTH-1:0] m10,
  input  logic signed [DATA_WIDTH-1:0] m11,
  input  logic signed [DATA_WIDTH-1:0] m12,
  input  logic signed [DATA_WIDTH-1:0] m20,
  input  logic signed [DATA_WIDTH-1:0] m21,
  input  logic signed [DATA_WIDTH-1:0] m22,
  output logic                         out_vld,
  output mtq_pkg::mag_t [3:0]          out_mag,
  output mtq_pkg::side_t               out_side
);

  localparam int DW   = DATA_WIDTH;
  localparam int BASE = (DW > FRAC_BITS + 1) ? DW : FRAC_BITS + 1;
  localparam int CW   = BASE + 3;
  localparam int POSW = $clog2(CW);
  localparam int SHW  = $clog2(CW + 1);
  localparam int EXW  = CW + mtq_pkg::MAG_W;
  localparam logic signed [CW-1:0] ONE =
    {{(CW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic signed [DW-1:0] raw [9];
  logic signed [CW-1:0] e   [9];

  assign raw[0] = m00;
  assign raw[1] = m01;
  assign raw[2] = m02;
  assign raw[3] = m10;
  assign raw[4] = m11;
  assign raw[5] = m12;
  assign raw[6] = m20;
  assign raw[7] = m21;
  assign raw[8] = m22;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e[i] = {{(CW - DW){raw[i][DW-1]}}, raw[i]};
    end
  end

  // Stage 1: trace and pivot choice
  logic                 vld1_r;
  logic signed [CW-1:0] m1_r [9];
  logic [1:0]           piv1_r;
  logic [1:0]           piv1_nxt;
  logic signed [CW-1:0] trace;
  logic signed [CW-1:0] dsel;

  always_comb begin
    trace = e[0] + e[4] + e[8];
    piv1_nxt = mtq_pkg::PIV_X;
    dsel = e[0];
    if (e[4] > e[0]) begin
      piv1_nxt = mtq_pkg::PIV_Y;
      dsel = e[4];
    end
    if (e[8] > dsel) piv1_nxt = mtq_pkg::PIV_Z;
    if (trace > 0) piv1_nxt = mtq_pkg::PIV_W;
  end

  // Stage 2: components, c[pivot] holds the square-root argument
  logic                 vld2_r;
  logic signed [CW-1:0] c2_r [4];
  logic signed [CW-1:0] c2_nxt [4];
  logic [1:0]           piv2_r;

  always_comb begin
    unique case (piv1_r)
      mtq_pkg::PIV_X: begin
        c2_nxt[1] = m1_r[0] - m1_r[4] - m1_r[8] + ONE;
        c2_nxt[0] = m1_r[7] - m1_r[5];
        c2_nxt[2] = m1_r[3] + m1_r[1];
        c2_nxt[3] = m1_r[6] + m1_r[2];
      end
      mtq_pkg::PIV_Y: begin
        c2_nxt[2] = m1_r[4] - m1_r[8] - m1_r[0] + ONE;
        c2_nxt[0] = m1_r[2] - m1_r[6];
        c2_nxt[3] = m1_r[7] + m1_r[5];
        c2_nxt[1] = m1_r[1] + m1_r[3];
      end
      mtq_pkg::PIV_Z: begin
        c2_nxt[3] = m1_r[8] - m1_r[0] - m1_r[4] + ONE;
        c2_nxt[0] = m1_r[3] - m1_r[1];
        c2_nxt[1] = m1_r[2] + m1_r[6];
        c2_nxt[2] = m1_r[5] + m1_r[7];
      end
      default: begin
        c2_nxt[0] = m1_r[0] + m1_r[4] + m1_r[8] + ONE;
        c2_nxt[1] = m1_r[7] - m1_r[5];
        c2_nxt[2] = m1_r[2] - m1_r[6];
        c2_nxt[3] = m1_r[3] - m1_r[1];
      end
    endcase
  end

  // Stage 3: sign and magnitude, largest magnitude
  logic              vld3_r;
  logic [CW-1:0]     mag3_r [4];
  logic [CW-1:0]     mag3_nxt [4];
  logic [CW-1:0]     mx3_r;
  logic [CW-1:0]     mxa;
  logic [CW-1:0]     mxb;
  mtq_pkg::side_t    side3_r;
  mtq_pkg::side_t    side3_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      side3_nxt.neg[i] = c2_r[i][CW-1];
      mag3_nxt[i] = c2_r[i][CW-1] ? -c2_r[i] : c2_r[i];
    end
    side3_nxt.pivot = piv2_r;
    side3_nxt.inv   = (c2_r[piv2_r] <= 0);
    mxa = (mag3_nxt[1] > mag3_nxt[0]) ? mag3_nxt[1] : mag3_nxt[0];
    mxb = (mag3_nxt[3] > mag3_nxt[2]) ? mag3_nxt[3] : mag3_nxt[2];
  end

  // Stage 4: shift all four so the largest lands in [2^29, 2^30)
  logic                 vld4_r;
  mtq_pkg::mag_t [3:0]  mag4_r;
  mtq_pkg::mag_t [3:0]  mag4_nxt;
  mtq_pkg::side_t       side4_r;
  logic [POSW-1:0]      pos;
  logic [SHW-1:0]       sh;
  logic [EXW-1:0]       ext [4];

  always_comb begin
    pos = '0;
    for (int b = 0; b < CW; b++) begin
      if (mx3_r[b]) pos = POSW'(b);
    end
    sh = SHW'(pos) + SHW'(1);
    for (int i = 0; i < 4; i++) begin
      ext[i] = {mag3_r[i], {mtq_pkg::MAG_W{1'b0}}} >> sh;
      mag4_nxt[i] = ext[i][mtq_pkg::MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_r    <= e;
    piv1_r  <= piv1_nxt;
    c2_r    <= c2_nxt;
    piv2_r  <= piv1_r;
    mag3_r  <= mag3_nxt;
    mx3_r   <= (mxb > mxa) ? mxb : mxa;
    side3_r <= side3_nxt;
    mag4_r  <= mag4_nxt;
    side4_r <= side3_r;
  end

  assign out_vld  = vld4_r;
  assign out_mag  = mag4_r;
  assign out_side = side4_r;

endmodule

/* hdl/mtq_sqrt.sv */
// Sum of squares and a one-bit-per-stage integer square root pipeline.
module mtq_sqrt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  mtq_pkg::mag_t [3:0]               in_mag,
  input  mtq_pkg::side_t                    in_side,
  output logic                              out_vld,
  output mtq_pkg::mag_t [3:0]               out_mag,
  output mtq_pkg::side_t                    out_side,
  output logic [mtq_pkg::ROOT_W-1:0]        out_len
);

  localparam int RW = mtq_pkg::ROOT_W;
  localparam int NW = mtq_pkg::N_W;

  logic                   vsq_r;
  logic [mtq_pkg::SQ_W-1:0] sq_r [4];
  mtq_pkg::mag_t [3:0]    msq_r;
  mtq_pkg::side_t         ssq_r;

  logic                   vps_r;
  logic [NW-2:0]          ps_r [2];
  mtq_pkg::mag_t [3:0]    mps_r;
  mtq_pkg::side_t         sps_r;

  // entry 0 holds N; entry s+1 is the state after root bit RW-1-s
  logic                   vld_r  [RW+1];
  logic [NW-1:0]          rem_r  [RW+1];
  logic [RW-1:0]          root_r [RW+1];
  mtq_pkg::mag_t [3:0]    mag_r  [RW+1];
  mtq_pkg::side_t         side_r [RW+1];
  logic [NW-1:0]          inc    [RW];

  always_comb begin
    int b;
    for (int s = 0; s < RW; s++) begin
      b = RW - 1 - s;
      inc[s] = (NW'(root_r[s]) << (b + 1)) | (NW'(1) << (2 * b));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsq_r <= 1'b0;
      vps_r <= 1'b0;
      for (int s = 0; s <= RW; s++) vld_r[s] <= 1'b0;
    end else begin
      vsq_r    <= in_vld;
      vps_r    <= vsq_r;
      vld_r[0] <= vps_r;
      for (int s = 0; s < RW; s++) vld_r[s+1] <= vld_r[s];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) sq_r[i] <= in_mag[i] * in_mag[i];
    msq_r <= in_mag;
    ssq_r <= in_side;
    ps_r[0] <= (NW-1)'(sq_r[0]) + (NW-1)'(sq_r[1]);
    ps_r[1] <= (NW-1)'(sq_r[2]) + (NW-1)'(sq_r[3]);
    mps_r <= msq_r;
    sps_r <= ssq_r;
    rem_r[0]  <= NW'(ps_r[0]) + NW'(ps_r[1]);
    root_r[0] <= '0;
    mag_r[0]  <= mps_r;
    side_r[0] <= sps_r;
    for (int s = 0; s < RW; s++) begin
      if (rem_r[s] >= inc[s]) begin
        rem_r[s+1]  <= rem_r[s] - inc[s];
        root_r[s+1] <= root_r[s] | (RW'(1) << (RW - 1 - s));
      end else begin
        rem_r[s+1]  <= rem_r[s];
        root_r[s+1] <= root_r[s];
      end
      mag_r[s+1]  <= mag_r[s];
      side_r[s+1] <= side_r[s];
    end
  end

  assign out_vld  = vld_r[RW];
  assign out_mag  = mag_r[RW];
  assign out_side = side_r[RW];
  assign out_len  = root_r[RW];

endmodule

/* hdl/mtq_div.sv */
// Rounded division of each magnitude by the length, saturation and sign restore.
module mtq_div #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  mtq_pkg::mag_t [3:0]               in_mag,
  input  mtq_pkg::side_t                    in_side,
  input  logic [mtq_pkg::ROOT_W-1:0]        in_len,
  output logic                              out_valid,
  output logic signed [DATA_WIDTH-1:0]      out_q_w,
  output logic signed [DATA_WIDTH-1:0]      out_q_x,
  output logic signed [DATA_WIDTH-1:0]      out_q_y,
  output logic signed [DATA_WIDTH-1:0]      out_q_z,
  output logic [1:0]                        out_pivot,
  output logic                              out_invalid
);

  localparam int DW   = DATA_WIDTH;
  localparam int RW   = mtq_pkg::ROOT_W;
  localparam int QW   = FRAC_BITS + 1;
  localparam int NW   = mtq_pkg::MAG_W + FRAC_BITS + 1;
  localparam int CMPW = (QW > DW) ? QW : DW;
  localparam logic [CMPW-1:0] LIM = {{(CMPW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};

  // entry 0 holds the rounded numerators; entry k+1 after quotient bit QW-1-k
  logic            vld_r  [QW+1];
  logic [NW-1:0]   rem_r  [QW+1][4];
  logic [QW-1:0]   q_r    [QW+1][4];
  logic [RW-1:0]   len_r  [QW+1];
  mtq_pkg::side_t  side_r [QW+1];
  logic [NW-1:0]   dsh    [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      dsh[k] = NW'(len_r[k]) << (QW - 1 - k);
    end
  end

  logic                 vo_r;
  logic signed [DW-1:0] qo_r [4];
  logic signed [DW-1:0] qo_nxt [4];
  mtq_pkg::side_t       so_r;
  logic [CMPW-1:0]      t_ext [4];
  logic [DW-1:0]        tsat  [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t_ext[i] = CMPW'(q_r[QW][i]);
      tsat[i]  = (t_ext[i] > LIM) ? LIM[DW-1:0] : t_ext[i][DW-1:0];
      if (side_r[QW].inv) qo_nxt[i] = '0;
      else if (side_r[QW].neg[i]) qo_nxt[i] = (~tsat[i]) + DW'(1);
      else qo_nxt[i] = tsat[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
      for (int k = 0; k <= QW; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 0; k < QW; k++) vld_r[k+1] <= vld_r[k];
      vo_r <= vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      rem_r[0][i] <= (NW'(in_mag[i]) << FRAC_BITS) + NW'(in_len >> 1);
      q_r[0][i]   <= '0;
    end
    len_r[0]  <= in_len;
    side_r[0] <= in_side;
    for (int k = 0; k < QW; k++) begin
      for (int i = 0; i < 4; i++) begin
        if (rem_r[k][i] >= dsh[k]) begin
          rem_r[k+1][i] <= rem_r[k][i] - dsh[k];
          q_r[k+1][i]   <= q_r[k][i] | (QW'(1) << (QW - 1 - k));
        end else begin
          rem_r[k+1][i] <= rem_r[k][i];
          q_r[k+1][i]   <= q_r[k][i];
        end
      end
      len_r[k+1]  <= len_r[k];
      side_r[k+1] <= side_r[k];
    end
    qo_r <= qo_nxt;
    so_r <= side_r[QW];
  end

  assign out_valid   = vo_r;
  assign out_q_w     = qo_r[0];
  assign out_q_x     = qo_r[1];
  assign out_q_y     = qo_r[2];
  assign out_q_z     = qo_r[3];
  assign out_pivot   = so_r.pivot;
  assign out_invalid = so_r.inv;

endmodule

/* hdl/matrix_to_quaternion_core.sv */
// Rotation matrix to unit quaternion converter, top level.
//
// Input: nine signed matrix elements on in_m00..in_m22 with FRAC_BITS fraction
// bits. An item is taken on a rising edge with start high and busy low; busy is
// always low, so a new matrix may be offered every cycle.
// Output: out_valid pulses for one cycle with out_q_w..out_q_z (unit quaternion,
// FRAC_BITS fraction bits), out_pivot (0 w, 1 x, 2 y, 3 z) and out_invalid.
// When the pivot argument is not positive the components are zero and
// out_invalid is set; out_pivot still shows the chosen component.
// The pipeline has 4 front stages, 3 stages for the sum of squares, 31
// square-root stages (one root bit each), one numerator stage, FRAC_BITS + 1
// division stages (one quotient bit each, four lanes) and the output register.
// Throughput is one item per cycle.
// Results are items in input order; the receiver cannot stall, so nothing
// waits inside the pipeline. Synchronous reset clears all valid bits and
// drops items in flight.
module matrix_to_quaternion_core #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_m00,
  input  logic signed [DATA_WIDTH-1:0] in_m01,
  input  logic signed [DATA_WIDTH-1:0] in_m02,
  input  logic signed [DATA_WIDTH-1:0] in_m10,
  input  logic signed [DATA_WIDTH-1:0] in_m11,
  input  logic signed [DATA_WIDTH-1:0] in_m12,
  input  logic signed [DATA_WIDTH-1:0] in_m20,
  input  logic signed [DATA_WIDTH-1:0] in_m21,
  input  logic signed [DATA_WIDTH-1:0] in_m22,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_q_w,
  output logic signed [DATA_WIDTH-1:0] out_q_x,
  output logic signed [DATA_WIDTH-1:0] out_q_y,
  output logic signed [DATA_WIDTH-1:0] out_q_z,
  output logic [1:0]                   out_pivot,
  output logic                         out_invalid
);

  logic                              acc;
  logic                              f_vld;
  mtq_pkg::mag_t [3:0]               f_mag;
  mtq_pkg::side_t                    f_side;
  logic                              s_vld;
  mtq_pkg::mag_t [3:0]               s_mag;
  mtq_pkg::side_t                    s_side;
  logic [mtq_pkg::ROOT_W-1:0]        s_len;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  mtq_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (acc),
    .m00     (in_m00),
    .m01     (in_m01),
    .m02     (in_m02),
    .m10     (in_m10),
    .m11     (in_m11),
    .m12     (in_m12),
    .m20     (in_m20),
    .m21     (in_m21),
    .m22     (in_m22),
    .out_vld (f_vld),
    .out_mag (f_mag),
    .out_side(f_side)
  );

  mtq_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (f_vld),
    .in_mag  (f_mag),
    .in_side (f_side),
    .out_vld (s_vld),
    .out_mag (s_mag),
    .out_side(s_side),
    .out_len (s_len)
  );

  mtq_div #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (s_vld),
    .in_mag     (s_mag),
    .in_side    (s_side),
    .in_len     (s_len),
    .out_valid  (out_valid),
    .out_q_w    (out_q_w),
    .out_q_x    (out_q_x),
    .out_q_y    (out_q_y),
    .out_q_z    (out_q_z),
    .out_pivot  (out_pivot),
    .out_invalid(out_invalid)
  );

endmodule
